// ===== rtl/psvc_pkg.sv =====
// Shared types and constants for the path segment velocity compiler.
// No dependencies; every other file in this folder imports it.
`timescale 1ns / 1ps

package psvc_pkg;

   localparam logic [1:0] KIND_HEAD  = 2'd0;
   localparam logic [1:0] KIND_LINE  = 2'd1;
   localparam logic [1:0] KIND_CURVE = 2'd2;
   localparam logic [1:0] KIND_END   = 2'd3;

   localparam logic [14:0] STEP_MAX = 15'd32767;

   // Last iteration index of the square root, the step division, the
   // velocity quotient division and the small velocity root.
   localparam logic [4:0] ROOT_LAST  = 5'd31;
   localparam logic [4:0] DIV_LAST   = 5'd31;
   localparam logic [4:0] QDIV_LAST  = 5'd17;
   localparam logic [4:0] FROOT_LAST = 5'd8;

   typedef enum logic [4:0] {
      OP_IDLE,
      OP_LOAD,
      OP_HEAD,
      OP_SQX,
      OP_SQY,
      OP_RINIT,
      OP_RSTEP,
      OP_DINIT,
      OP_DSTEP,
      OP_STEPS,
      OP_MLO,
      OP_MHI,
      OP_QSTEP,
      OP_FSTEP,
      OP_VEL,
      OP_UPD,
      OP_EMIT_LINE,
      OP_EMIT_END
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [4:0] idx;
      logic       axis;
   } cmd_type;

   typedef struct packed {
      logic zero_len;
      logic out_free;
   } sts_type;

endpackage

// ===== rtl/psvc_ctrl.sv =====
// Sequencer of the path segment velocity compiler: walks the datapath
// through each segment's operations. Depends on psvc_pkg.
`timescale 1ns / 1ps

module psvc_ctrl
   import psvc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_seg_kind,
   output logic       req_stall,
   input  sts_type    sts,
   output cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_HEAD, S_END, S_SQX, S_SQY, S_CHK, S_ROOT, S_DINIT, S_DIV,
      S_STEPS, S_MLO, S_MHI, S_QDIV, S_FROOT, S_VEL, S_UPD, S_EMIT
   } state_type;

   state_type  state_ff;
   logic [4:0] cnt_ff;
   logic       axis_ff;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd.op   = OP_IDLE;
      cmd.idx  = cnt_ff;
      cmd.axis = axis_ff;
      unique case (state_ff)
         S_IDLE:  if (req_valid) cmd.op = OP_LOAD;
         S_HEAD:  cmd.op = OP_HEAD;
         S_END:   if (sts.out_free) cmd.op = OP_EMIT_END;
         S_SQX:   cmd.op = OP_SQX;
         S_SQY:   cmd.op = OP_SQY;
         S_CHK:   cmd.op = OP_RINIT;
         S_ROOT:  cmd.op = OP_RSTEP;
         S_DINIT: cmd.op = OP_DINIT;
         S_DIV:   cmd.op = OP_DSTEP;
         S_STEPS: cmd.op = OP_STEPS;
         S_MLO:   cmd.op = OP_MLO;
         S_MHI:   cmd.op = OP_MHI;
         S_QDIV:  cmd.op = OP_QSTEP;
         S_FROOT: cmd.op = OP_FSTEP;
         S_VEL:   cmd.op = OP_VEL;
         S_UPD:   cmd.op = OP_UPD;
         S_EMIT:  if (sts.out_free) cmd.op = OP_EMIT_LINE;
         default: cmd.op = OP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         axis_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               cnt_ff  <= '0;
               axis_ff <= 1'b0;
               if (req_valid) begin
                  unique case (req_seg_kind)
                     KIND_HEAD:  state_ff <= S_HEAD;
                     KIND_LINE:  state_ff <= S_SQX;
                     KIND_CURVE: state_ff <= S_IDLE;
                     KIND_END:   state_ff <= S_END;
                     default:    state_ff <= S_IDLE;
                  endcase
               end
            end
            S_HEAD: state_ff <= S_IDLE;
            S_END:  if (sts.out_free) state_ff <= S_IDLE;
            S_SQX:  state_ff <= S_SQY;
            S_SQY:  state_ff <= S_CHK;
            S_CHK: begin
               cnt_ff   <= '0;
               state_ff <= sts.zero_len ? S_IDLE : S_ROOT;
            end
            S_ROOT: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == ROOT_LAST) state_ff <= S_DINIT;
            end
            S_DINIT: begin
               cnt_ff   <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == DIV_LAST) state_ff <= S_STEPS;
            end
            S_STEPS: begin
               axis_ff  <= 1'b0;
               state_ff <= S_MLO;
            end
            S_MLO: state_ff <= S_MHI;
            S_MHI: begin
               cnt_ff   <= '0;
               state_ff <= S_QDIV;
            end
            S_QDIV: begin
               if (cnt_ff == QDIV_LAST) begin
                  cnt_ff   <= '0;
                  state_ff <= S_FROOT;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            S_FROOT: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == FROOT_LAST) state_ff <= S_VEL;
            end
            S_VEL: begin
               if (!axis_ff) begin
                  axis_ff  <= 1'b1;
                  state_ff <= S_MLO;
               end else begin
                  axis_ff  <= 1'b0;
                  state_ff <= S_UPD;
               end
            end
            S_UPD: begin
               axis_ff <= 1'b1;
               if (axis_ff) state_ff <= S_EMIT;
            end
            S_EMIT: if (sts.out_free) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/psvc_dpath.sv =====
// Datapath of the path segment velocity compiler: position, offsets, the
// shared shift-and-subtract unit and the result word register. Depends on psvc_pkg.
`timescale 1ns / 1ps

module psvc_dpath
   import psvc_pkg::*;
#(
   parameter int POSITION_SHIFT = 5
)(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic signed [15:0] req_seg_x,
   input  logic signed [15:0] req_seg_y,
   input  logic [7:0]         req_seg_speed,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [14:0]        rsp_step_count,
   output logic signed [8:0]  rsp_x_velocity,
   output logic signed [8:0]  rsp_y_velocity,
   output logic               rsp_is_terminator
);

   localparam int PW = 16 + POSITION_SHIFT;
   localparam logic [33:0] OFF_LIM = 34'd1073741824;

   function automatic logic [30:0] clamp_mag(input logic signed [33:0] d);
      logic [33:0] m;
      begin
         m = d[33] ? 34'(-d) : 34'(d);
         return (m > OFF_LIM) ? OFF_LIM[30:0] : m[30:0];
      end
   endfunction

   logic signed [31:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [31:0] p_x_ff, p_x_in, p_y_ff, p_y_in;
   logic [7:0]         sp_ff, sp_in;
   logic [15:0]        sp2_ff, sp2_in;
   logic [30:0]        mag_x_ff, mag_x_in, mag_y_ff, mag_y_in;
   logic               neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [60:0]        sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [61:0]        s_ff, s_in;
   logic [79:0]        w_ff, w_in, r_ff, r_in;
   logic [31:0]        q_ff, q_in;
   logic [7:0]         rem_ff, rem_in;
   logic [8:0]         f_ff, f_in;
   logic [14:0]        n_ff, n_in;
   logic signed [8:0]  vx_ff, vx_in, vy_ff, vy_in;
   logic               rv_ff, rv_in;
   logic [14:0]        rn_ff, rn_in;
   logic signed [8:0]  rvx_ff, rvx_in, rvy_ff, rvy_in;
   logic               rt_ff, rt_in;

   logic signed [PW-1:0] px_w, py_w;
   logic signed [33:0]   dx_w, dy_w;
   logic [79:0]          bb, trial;
   logic [8:0]           rem2;
   logic                 ge;
   logic [32:0]          nq;
   logic [60:0]          dsq;
   logic [47:0]          plo;
   logic [44:0]          phi;
   logic [8:0]           ftrial;
   logic [17:0]          fsq;
   logic [3:0]           fbit;
   logic [9:0]           mp;
   logic [8:0]           mn;
   logic [7:0]           m;
   logic signed [8:0]    v;
   logic                 neg;
   logic signed [24:0]   upd;

   assign sts.zero_len = (s_ff == 62'd0) || (sp_ff == 8'd0);
   assign sts.out_free = !rv_ff || !rsp_stall;

   always_comb begin
      px_w   = $signed(PW'(req_seg_x)) <<< POSITION_SHIFT;
      py_w   = $signed(PW'(req_seg_y)) <<< POSITION_SHIFT;
      dx_w   = 34'(px_w) - 34'(cur_x_ff);
      dy_w   = 34'(py_w) - 34'(cur_y_ff);
      bb     = 80'd1 << {~cmd.idx, 1'b0};
      trial  = r_ff + bb;
      rem2   = {rem_ff, q_ff[31]};
      ge     = (rem2 >= {1'b0, sp_ff});
      nq     = ({1'b0, q_ff} + 33'd1) >> 1;
      dsq    = cmd.axis ? sqy_ff : sqx_ff;
      plo    = sp2_ff * dsq[31:0];
      phi    = sp2_ff * dsq[60:32];
      fbit   = FROOT_LAST[3:0] - cmd.idx[3:0];
      ftrial = f_ff | (9'd1 << fbit);
      fsq    = 18'(ftrial) * 18'(ftrial);
      neg    = cmd.axis ? neg_y_ff : neg_x_ff;
      mp     = (10'(f_ff) + 10'd1) >> 1;
      mn     = (f_ff == 9'd0) ? 9'd0 : ((f_ff - 9'd1) >> 1);
      m      = neg ? mn[7:0] : mp[7:0];
      v      = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
      upd    = $signed({1'b0, n_ff}) * (cmd.axis ? vy_ff : vx_ff);

      cur_x_in = cur_x_ff;  cur_y_in = cur_y_ff;
      p_x_in   = p_x_ff;    p_y_in   = p_y_ff;
      sp_in    = sp_ff;     sp2_in   = sp2_ff;
      mag_x_in = mag_x_ff;  mag_y_in = mag_y_ff;
      neg_x_in = neg_x_ff;  neg_y_in = neg_y_ff;
      sqx_in   = sqx_ff;    sqy_in   = sqy_ff;
      s_in     = s_ff;
      w_in     = w_ff;      r_in     = r_ff;
      q_in     = q_ff;      rem_in   = rem_ff;
      f_in     = f_ff;      n_in     = n_ff;
      vx_in    = vx_ff;     vy_in    = vy_ff;
      rn_in    = rn_ff;     rvx_in   = rvx_ff;
      rvy_in   = rvy_ff;    rt_in    = rt_ff;
      rv_in    = rv_ff && rsp_stall;

      case (cmd.op)
         OP_LOAD: begin
            p_x_in   = 32'(px_w);
            p_y_in   = 32'(py_w);
            sp_in    = req_seg_speed;
            sp2_in   = req_seg_speed * req_seg_speed;
            mag_x_in = clamp_mag(dx_w);
            mag_y_in = clamp_mag(dy_w);
            neg_x_in = dx_w[33];
            neg_y_in = dy_w[33];
         end
         OP_HEAD: begin
            cur_x_in = p_x_ff;
            cur_y_in = p_y_ff;
         end
         OP_SQX: sqx_in = 61'(mag_x_ff * mag_x_ff);
         OP_SQY: begin
            sqy_in = 61'(mag_y_ff * mag_y_ff);
            s_in   = 62'(sqx_ff) + 62'(61'(mag_y_ff * mag_y_ff));
         end
         OP_RINIT: begin
            w_in = 80'(s_ff) << 2;
            r_in = '0;
         end
         // One digit of the square root of 4*s per cycle.
         OP_RSTEP: begin
            if (w_ff >= trial) begin
               w_in = w_ff - trial;
               r_in = (r_ff >> 1) + bb;
            end else begin
               r_in = r_ff >> 1;
            end
         end
         OP_DINIT: begin
            q_in   = r_ff[31:0];
            rem_in = '0;
         end
         OP_DSTEP: begin
            rem_in = ge ? 8'(rem2 - {1'b0, sp_ff}) : rem2[7:0];
            q_in   = {q_ff[30:0], ge};
         end
         OP_STEPS: n_in = (nq > 33'(STEP_MAX)) ? STEP_MAX : nq[14:0];
         // The squared velocity numerator 4*sp^2*d^2 is built from two halves.
         OP_MLO: w_in = 80'(plo);
         OP_MHI: begin
            w_in = (w_ff + (80'(phi) << 32)) << 2;
            r_in = 80'(s_ff) << 17;
            q_in = '0;
            f_in = '0;
         end
         OP_QSTEP: begin
            if (r_ff <= w_ff) w_in = w_ff - r_ff;
            q_in = {q_ff[30:0], (r_ff <= w_ff)};
            r_in = r_ff >> 1;
         end
         OP_FSTEP: if (fsq <= q_ff[17:0]) f_in = ftrial;
         OP_VEL: begin
            if (cmd.axis) vy_in = v;
            else          vx_in = v;
         end
         OP_UPD: begin
            if (cmd.axis) cur_y_in = cur_y_ff + 32'(upd);
            else          cur_x_in = cur_x_ff + 32'(upd);
         end
         OP_EMIT_LINE: begin
            rv_in  = 1'b1;
            rn_in  = n_ff;
            rvx_in = vx_ff;
            rvy_in = vy_ff;
            rt_in  = 1'b0;
         end
         OP_EMIT_END: begin
            rv_in    = 1'b1;
            rn_in    = '0;
            rvx_in   = '0;
            rvy_in   = '0;
            rt_in    = 1'b1;
            cur_x_in = '0;
            cur_y_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff <= '0;
         cur_y_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         rv_ff    <= rv_in;
      end
      p_x_ff   <= p_x_in;   p_y_ff   <= p_y_in;
      sp_ff    <= sp_in;    sp2_ff   <= sp2_in;
      mag_x_ff <= mag_x_in; mag_y_ff <= mag_y_in;
      neg_x_ff <= neg_x_in; neg_y_ff <= neg_y_in;
      sqx_ff   <= sqx_in;   sqy_ff   <= sqy_in;
      s_ff     <= s_in;
      w_ff     <= w_in;     r_ff     <= r_in;
      q_ff     <= q_in;     rem_ff   <= rem_in;
      f_ff     <= f_in;     n_ff     <= n_in;
      vx_ff    <= vx_in;    vy_ff    <= vy_in;
      rn_ff    <= rn_in;    rvx_ff   <= rvx_in;
      rvy_ff   <= rvy_in;   rt_ff    <= rt_in;
   end

   assign rsp_valid         = rv_ff;
   assign rsp_step_count    = rn_ff;
   assign rsp_x_velocity    = rvx_ff;
   assign rsp_y_velocity    = rvy_ff;
   assign rsp_is_terminator = rt_ff;

endmodule

// ===== rtl/path_segment_velocity_compiler_core.sv =====
// Path segment velocity compiler. Segments are taken one at a time. A head
// segment passes through its own state, a curve segment gives no word, and an
// end segment waits for the result register. A line segment uses one shared
// shift-and-subtract unit for a 32-step square root, a 32-step division by
// the speed and, per axis, an 18-step quotient and a 9-step root. A result
// word waits in its own register, so the next segment is taken while it is
// still stalled. Top level; depends on psvc_pkg, psvc_ctrl and psvc_dpath.
`timescale 1ns / 1ps

module path_segment_velocity_compiler_core
   import psvc_pkg::*;
#(
   parameter int POSITION_SHIFT = 5
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_seg_kind,
   input  logic signed [15:0] req_seg_x,
   input  logic signed [15:0] req_seg_y,
   input  logic [7:0]         req_seg_speed,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [14:0]        rsp_step_count,
   output logic signed [8:0]  rsp_x_velocity,
   output logic signed [8:0]  rsp_y_velocity,
   output logic               rsp_is_terminator
);

   cmd_type cmd;
   sts_type sts;

   psvc_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_seg_kind (req_seg_kind),
      .req_stall    (req_stall),
      .sts          (sts),
      .cmd          (cmd)
   );

   psvc_dpath #(
      .POSITION_SHIFT (POSITION_SHIFT)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_seg_x         (req_seg_x),
      .req_seg_y         (req_seg_y),
      .req_seg_speed     (req_seg_speed),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_step_count    (rsp_step_count),
      .rsp_x_velocity    (rsp_x_velocity),
      .rsp_y_velocity    (rsp_y_velocity),
      .rsp_is_terminator (rsp_is_terminator)
   );

endmodule

// ===== rtl/psvc_chk.sv =====
// Port-level checks for the path segment velocity compiler, bound to the top
// level. Depends on psvc_pkg and path_segment_velocity_compiler_core.
`timescale 1ns / 1ps

module psvc_chk
   import psvc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic [1:0]        req_seg_kind,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [14:0]       rsp_step_count,
   input logic signed [8:0] rsp_x_velocity,
   input logic signed [8:0] rsp_y_velocity,
   input logic              rsp_is_terminator
);

   logic req_acc;
   assign req_acc = req_valid && !req_stall;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_step_count) &&
         $stable(rsp_x_velocity) && $stable(rsp_y_velocity) &&
         $stable(rsp_is_terminator))
      else $error("stalled result word changed");

   a_term_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_terminator |->
         rsp_step_count == 15'd0 && rsp_x_velocity == 9'sd0 &&
         rsp_y_velocity == 9'sd0)
      else $error("terminator word carries nonzero fields");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_seg_kind != KIND_CURVE |=> req_stall)
      else $error("new segment taken while one is in work");

   a_curve_quiet: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_seg_kind == KIND_CURVE && !rsp_valid |=> !rsp_valid)
      else $error("curve segment produced a word");

   a_end_word: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_seg_kind == KIND_END && !rsp_valid |->
         ##2 (rsp_valid && rsp_is_terminator))
      else $error("end segment did not give the terminator word");

endmodule

bind path_segment_velocity_compiler_core psvc_chk u_psvc_chk (.*);
